// ===== rtl/afd_pkg.sv =====
package afd_pkg;

    // Header layout constants
    localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
    localparam logic [7:0]  SYNC_LOW_MASK  = 8'hF0;
    localparam logic [7:0]  LAYER_MASK     = 8'h06;
    localparam logic [3:0]  HDR_LEN_PLAIN  = 4'd7;
    localparam logic [3:0]  HDR_LEN_CRC    = 4'd9;
    localparam logic [3:0]  MAX_RATE_INDEX = 4'd12;
    localparam logic [2:0]  WINDOW_FULL    = 3'd7;
    localparam logic [1:0]  CRC_BYTES      = 2'd2;

    // Widths of the fields
    localparam int unsigned BYTE_BITS     = 8;
    localparam int unsigned FRAME_NUM_BITS = 32;
    localparam int unsigned LEN_BITS      = 13;
    localparam int unsigned LIMIT_BITS    = 17;
    localparam int unsigned CFG_IDX_BITS  = 2;
    localparam int unsigned TDATA_BITS    = 56;

    // Register reset values
    localparam logic [2:0]            RST_OBJECT_TYPE    = 3'd2;
    localparam logic [3:0]            RST_RATE_INDEX     = 4'd4;
    localparam logic [2:0]            RST_CHANNEL_CONFIG = 3'd2;
    localparam logic [LIMIT_BITS-1:0] RST_RESYNC_LIMIT   = 17'h10000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_OBJECT_TYPE    = 2'd0,
        REG_RATE_INDEX     = 2'd1,
        REG_CHANNEL_CONFIG = 2'd2,
        REG_RESYNC_LIMIT   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_CRC     = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_ENDED   = 2'd3
    } phase_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_END     = 1'b1
    } kind_t;

    // One result record as it travels through the queue
    typedef struct packed {
        kind_t                      kind;
        logic [BYTE_BITS-1:0]       payload_byte;
        logic                       last_of_frame;
        logic [FRAME_NUM_BITS-1:0]  frame_number;
        logic [LEN_BITS-1:0]        payload_length;
    } result_t;

endpackage

// ===== rtl/afd_front.sv =====
module afd_front #(
    parameter int FRAME_COUNT_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [afd_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [afd_pkg::LIMIT_BITS-1:0]        cfg_data,
    input  logic                                  byte_accept,
    input  logic [afd_pkg::BYTE_BITS-1:0]         byte_in,
    output logic                                  push,
    output afd_pkg::result_t                      push_data
);

    logic [2:0]                      exp_obj_reg;
    logic [3:0]                      exp_rate_reg;
    logic [2:0]                      exp_chan_reg;
    logic [afd_pkg::LIMIT_BITS-1:0]  limit_reg;

    logic [6:0][7:0]                 window_reg, window_next;
    logic [2:0]                      fill_reg, fill_next;
    afd_pkg::phase_t                 phase_reg, phase_next;
    logic [1:0]                      crc_left_reg, crc_left_next;
    logic [afd_pkg::LEN_BITS-1:0]    left_reg, left_next;
    logic [afd_pkg::LEN_BITS-1:0]    size_reg, size_next;
    logic [afd_pkg::LIMIT_BITS-1:0]  slide_reg, slide_next;
    logic [FRAME_COUNT_BITS-1:0]     fcount_reg, fcount_next;

    logic [6:0][7:0]                 win;
    logic [63:0]                     fcount_wide;
    logic [2:0]                      obj;
    logic [3:0]                      rate;
    logic [2:0]                      chan;
    logic [afd_pkg::LEN_BITS-1:0]    flen;
    logic [3:0]                      hlen;
    logic                            hdr_ok;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_obj_reg  <= afd_pkg::RST_OBJECT_TYPE;
            exp_rate_reg <= afd_pkg::RST_RATE_INDEX;
            exp_chan_reg <= afd_pkg::RST_CHANNEL_CONFIG;
            limit_reg    <= afd_pkg::RST_RESYNC_LIMIT;
        end
        else if (cfg_valid)
        begin
            unique case (afd_pkg::cfg_index_t'(cfg_index))
                afd_pkg::REG_OBJECT_TYPE:    exp_obj_reg  <= cfg_data[2:0];
                afd_pkg::REG_RATE_INDEX:     exp_rate_reg <= cfg_data[3:0];
                afd_pkg::REG_CHANNEL_CONFIG: exp_chan_reg <= cfg_data[2:0];
                afd_pkg::REG_RESYNC_LIMIT:   limit_reg    <= cfg_data;
                default:                     exp_obj_reg  <= exp_obj_reg;
            endcase
        end
    end

    // Window after the incoming byte shifts in; header fields decoded from it
    always_comb
    begin
        win    = {byte_in, window_reg[6:1]};
        obj    = 3'({1'b0, win[2][7:6]} + 3'd1);
        rate   = win[2][5:2];
        chan   = {win[2][0], win[3][7:6]};
        flen   = {win[3][1:0], win[4], win[5][7:5]};
        hlen   = win[1][0] ? afd_pkg::HDR_LEN_PLAIN : afd_pkg::HDR_LEN_CRC;
        hdr_ok = (win[0] == afd_pkg::SYNC_BYTE)
              && ((win[1] & afd_pkg::SYNC_LOW_MASK) == afd_pkg::SYNC_LOW_MASK)
              && ((win[1] & afd_pkg::LAYER_MASK) == 8'h00)
              && (rate <= afd_pkg::MAX_RATE_INDEX)
              && (flen > afd_pkg::LEN_BITS'(hlen))
              && (win[6][1:0] == 2'b00)
              && (obj == exp_obj_reg)
              && (rate == exp_rate_reg)
              && (chan == exp_chan_reg);
    end

    assign fcount_wide = 64'(fcount_reg);

    always_comb
    begin
        window_next   = window_reg;
        fill_next     = fill_reg;
        phase_next    = phase_reg;
        crc_left_next = crc_left_reg;
        left_next     = left_reg;
        size_next     = size_reg;
        slide_next    = slide_reg;
        fcount_next   = fcount_reg;
        push          = 1'b0;
        push_data     = '0;
        push_data.frame_number = fcount_wide[afd_pkg::FRAME_NUM_BITS-1:0];

        if (byte_accept)
        begin
            unique case (phase_reg)
                afd_pkg::PH_HUNT:
                begin
                    window_next = win;
                    if (fill_reg < afd_pkg::WINDOW_FULL)
                        fill_next = 3'(fill_reg + 3'd1);
                    // a check runs only once the window holds seven bytes
                    if (fill_reg >= 3'(afd_pkg::WINDOW_FULL - 3'd1))
                    begin
                        if (hdr_ok)
                        begin
                            size_next  = 13'(flen - afd_pkg::LEN_BITS'(hlen));
                            left_next  = 13'(flen - afd_pkg::LEN_BITS'(hlen));
                            slide_next = '0;
                            fill_next  = '0;
                            if (hlen == afd_pkg::HDR_LEN_CRC)
                            begin
                                crc_left_next = afd_pkg::CRC_BYTES;
                                phase_next    = afd_pkg::PH_CRC;
                            end
                            else
                                phase_next = afd_pkg::PH_PAYLOAD;
                        end
                        else if (slide_reg >= limit_reg)
                        begin
                            phase_next     = afd_pkg::PH_ENDED;
                            push           = 1'b1;
                            push_data.kind = afd_pkg::KIND_END;
                        end
                        else
                            slide_next = 17'(slide_reg + 17'd1);
                    end
                end
                afd_pkg::PH_CRC:
                begin
                    crc_left_next = (crc_left_reg != 2'd0) ? 2'(crc_left_reg - 2'd1)
                                                           : crc_left_reg;
                    if (crc_left_next == 2'd0)
                        phase_next = afd_pkg::PH_PAYLOAD;
                end
                afd_pkg::PH_PAYLOAD:
                begin
                    push                     = 1'b1;
                    push_data.kind           = afd_pkg::KIND_PAYLOAD;
                    push_data.payload_byte   = byte_in;
                    push_data.payload_length = size_reg;
                    push_data.last_of_frame  = (left_reg <= 13'd1);
                    if (left_reg <= 13'd1)
                    begin
                        left_next   = '0;
                        fcount_next = FRAME_COUNT_BITS'(fcount_reg + 1'b1);
                        phase_next  = afd_pkg::PH_HUNT;
                        fill_next   = '0;
                    end
                    else
                        left_next = 13'(left_reg - 13'd1);
                end
                afd_pkg::PH_ENDED:
                begin
                    phase_next = afd_pkg::PH_ENDED;
                end
                default:
                begin
                    phase_next = afd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            fill_reg     <= '0;
            phase_reg    <= afd_pkg::PH_HUNT;
            crc_left_reg <= '0;
            left_reg     <= '0;
            size_reg     <= '0;
            slide_reg    <= '0;
            fcount_reg   <= '0;
        end
        else
        begin
            window_reg   <= window_next;
            fill_reg     <= fill_next;
            phase_reg    <= phase_next;
            crc_left_reg <= crc_left_next;
            left_reg     <= left_next;
            size_reg     <= size_next;
            slide_reg    <= slide_next;
            fcount_reg   <= fcount_next;
        end
    end

endmodule

// ===== rtl/afd_queue.sv =====
module afd_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  afd_pkg::result_t  push_data,
    input  logic              pop,
    output afd_pkg::result_t  pop_data,
    output logic              not_empty,
    output logic              not_full
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    afd_pkg::result_t        mem [DEPTH];
    logic [PTR_BITS-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]       count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != (PTR_BITS+1)'(DEPTH));
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                               : PTR_BITS'(wr_ptr_reg + 1'b1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                               : PTR_BITS'(rd_ptr_reg + 1'b1);
        if (push && !pop)
            count_next = (PTR_BITS+1)'(count_reg + 1'b1);
        else if (pop && !push)
            count_next = (PTR_BITS+1)'(count_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/afd_back.sv =====
module afd_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_not_empty,
    input  afd_pkg::result_t                   q_data,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [afd_pkg::TDATA_BITS-1:0]     m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);

    logic                                  valid_reg, valid_next;
    logic [afd_pkg::TDATA_BITS-1:0]        tdata_reg;
    logic                                  tuser_reg;
    logic                                  tlast_reg;

    // refill the output stage whenever it is empty or being drained
    assign q_pop      = q_not_empty && (!valid_reg || m_tready);
    assign valid_next = q_pop || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            tdata_reg <= {3'b000, q_data.payload_length, q_data.frame_number,
                          q_data.payload_byte};
            tuser_reg <= q_data.kind;
            tlast_reg <= q_data.last_of_frame;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

endmodule

// ===== rtl/adts_frame_deframer.sv =====
// Channel    Dir  Handshake              Payload
// s_         in   s_tvalid / s_tready    s_tdata: stream_byte
// m_         out  m_tvalid / m_tready    m_tdata, m_tuser: kind, m_tlast: last_of_frame
// cfg_       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte per cycle sustained while the queue has room; the header check on the
// 7-byte window is combinational inside the front end, so each byte is decided
// the cycle it lands. A result is written to the queue at the edge that takes its
// byte and enters the output register once that is empty or being drained.
// rst_n is asynchronous, active low; it restores the register defaults and hunting.
// A stalled m_ side fills the 4-entry queue; s_tready drops only when it is full.
// cfg_ready is always high.
module adts_frame_deframer #(
    parameter int FRAME_COUNT_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // stream input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [afd_pkg::BYTE_BITS-1:0]       s_tdata,   // [7:0] stream_byte
    // result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [afd_pkg::TDATA_BITS-1:0]      m_tdata,   // [7:0] payload_byte,
                                                           // [39:8] frame_number,
                                                           // [52:40] payload_length
    output logic                                m_tuser,   // [0] kind
    output logic                                m_tlast,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [afd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [afd_pkg::LIMIT_BITS-1:0]      cfg_data
);

    logic              byte_accept;
    logic              push;
    afd_pkg::result_t  push_data;
    logic              q_pop;
    afd_pkg::result_t  q_data;
    logic              q_not_empty;
    logic              q_not_full;

    // each byte yields at most one result, so a free queue slot is enough
    assign s_tready    = q_not_full;
    assign byte_accept = s_tvalid && s_tready;
    assign cfg_ready   = 1'b1;

    // front end: window, header check, frame tracking
    afd_front #(
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .byte_accept (byte_accept),
        .byte_in     (s_tdata),
        .push        (push),
        .push_data   (push_data)
    );

    // decoupling queue between classification and output
    afd_queue #(
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_not_empty),
        .not_full  (q_not_full)
    );

    // back end: output register and stream packing
    afd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== sim/adts_frame_deframer_tb.sv =====
`timescale 1ns / 1ps

module adts_frame_deframer_tb;

    // ------------------------------------------------------------------
    // Deframer predictor and store of results still due.
    // take_byte() is called for every accepted stream transaction and
    // queues what the block must emit for it; check_result() pops the
    // oldest entry for every accepted result transaction.
    // ------------------------------------------------------------------
    class deframer_scoreboard;
        logic [2:0]  exp_obj;
        logic [3:0]  exp_rate;
        logic [2:0]  exp_chan;
        logic [16:0] limit;

        logic [7:0]  win [7];
        int unsigned fill;
        afd_pkg::phase_t ph;
        int unsigned crc_left;
        logic [12:0] left;
        logic [12:0] size;
        logic [16:0] slides;
        logic [31:0] frames;

        afd_pkg::result_t due [$];
        int unsigned errors;

        function new();
            exp_obj  = afd_pkg::RST_OBJECT_TYPE;
            exp_rate = afd_pkg::RST_RATE_INDEX;
            exp_chan = afd_pkg::RST_CHANNEL_CONFIG;
            limit    = afd_pkg::RST_RESYNC_LIMIT;
            foreach (win[i]) win[i] = 8'h00;
            fill     = 0;
            ph       = afd_pkg::PH_HUNT;
            crc_left = 0;
            left     = '0;
            size     = '0;
            slides   = '0;
            frames   = '0;
            errors   = 0;
        endfunction

        function void write_reg(afd_pkg::cfg_index_t idx, logic [16:0] val);
            case (idx)
                afd_pkg::REG_OBJECT_TYPE:    exp_obj  = val[2:0];
                afd_pkg::REG_RATE_INDEX:     exp_rate = val[3:0];
                afd_pkg::REG_CHANNEL_CONFIG: exp_chan = val[2:0];
                afd_pkg::REG_RESYNC_LIMIT:   limit    = val;
                default: ;
            endcase
        endfunction

        // header length (7 or 9) when the window holds an acceptable header, else 0
        function int unsigned header_len(output logic [12:0] flen);
            int unsigned hl;
            int unsigned obj;
            int unsigned blocks;
            logic [3:0]  rate;
            logic [2:0]  chan;
            flen = {win[3][1:0], win[4], win[5][7:5]};
            if (win[0] != 8'hFF || win[1][7:4] != 4'hF || win[1][2:1] != 2'b00)
                return 0;
            hl     = win[1][0] ? 7 : 9;
            obj    = win[2][7:6] + 1;
            rate   = win[2][5:2];
            chan   = {win[2][0], win[3][7:6]};
            blocks = win[6][1:0] + 1;
            if (rate > 12 || flen <= hl || blocks != 1)
                return 0;
            if (obj != exp_obj || rate != exp_rate || chan != exp_chan)
                return 0;
            return hl;
        endfunction

        function void take_byte(logic [7:0] b);
            int unsigned hl;
            int          i;
            logic [12:0] flen;
            afd_pkg::result_t r;
            case (ph)
                afd_pkg::PH_HUNT:
                begin
                    for (i = 0; i < 6; i++)
                        win[i] = win[i + 1];
                    win[6] = b;
                    if (fill < 7)
                        fill++;
                    if (fill == 7)
                    begin
                        hl = header_len(flen);
                        if (hl != 0)
                        begin
                            size   = 13'(flen - hl);
                            left   = size;
                            slides = '0;
                            fill   = 0;
                            if (hl == 9)
                            begin
                                crc_left = 2;
                                ph       = afd_pkg::PH_CRC;
                            end
                            else
                                ph = afd_pkg::PH_PAYLOAD;
                        end
                        else if (slides >= limit)
                        begin
                            ph               = afd_pkg::PH_ENDED;
                            r.kind           = afd_pkg::KIND_END;
                            r.payload_byte   = '0;
                            r.last_of_frame  = 1'b0;
                            r.frame_number   = frames;
                            r.payload_length = '0;
                            due = {due, r};
                        end
                        else
                            slides++;
                    end
                end
                afd_pkg::PH_CRC:
                begin
                    if (crc_left > 0)
                        crc_left--;
                    if (crc_left == 0)
                        ph = afd_pkg::PH_PAYLOAD;
                end
                afd_pkg::PH_PAYLOAD:
                begin
                    r.kind           = afd_pkg::KIND_PAYLOAD;
                    r.payload_byte   = b;
                    r.last_of_frame  = (left <= 1);
                    r.frame_number   = frames;
                    r.payload_length = size;
                    due = {due, r};
                    if (left <= 1)
                    begin
                        left = '0;
                        frames++;
                        ph   = afd_pkg::PH_HUNT;
                        fill = 0;
                    end
                    else
                        left--;
                end
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return due.size();
        endfunction

        function void flag_field(string field, longint unsigned want, longint unsigned got);
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(logic k, logic [7:0] pb, logic lf, logic [31:0] fn,
                                   logic [12:0] pl);
            afd_pkg::result_t want;
            if (due.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, got kind %0h byte %0h frame %0h",
                         $time, k, pb, fn);
                errors++;
                return;
            end
            want = due.pop_front();
            if (k !== want.kind)
                flag_field("kind", want.kind, k);
            if (pb !== want.payload_byte)
                flag_field("payload_byte", want.payload_byte, pb);
            if (lf !== want.last_of_frame)
                flag_field("last_of_frame", want.last_of_frame, lf);
            if (fn !== want.frame_number)
                flag_field("frame_number", want.frame_number, fn);
            if (pl !== want.payload_length)
                flag_field("payload_length", want.payload_length, pl);
        endfunction
    endclass

    // Header fields as laid out on the wire; random side bits are filled in
    // when the header is serialized.
    typedef struct {
        logic [7:0]  sync0;
        logic [3:0]  sync1;
        logic [1:0]  layer;
        logic        no_crc;
        logic [1:0]  profile;
        logic [3:0]  rate;
        logic [2:0]  chan;
        logic [12:0] flen;
        logic [1:0]  extra_blocks;
    } adts_hdr_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] stream_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;     // [7:0] payload_byte, [39:8] frame_number, [52:40] payload_length
    logic        m_tuser;     // [0] kind
    logic        m_tlast;     // last_of_frame
    logic        cfg_valid;
    logic        cfg_ready;
    afd_pkg::cfg_index_t cfg_index;
    logic [16:0] cfg_data;

    deframer_scoreboard sb;
    logic [7:0]  stream_q [$];     // bytes waiting to be offered on s_
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    adts_frame_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver backpressure, redrawn every cycle on the falling edge.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Monitor: both channels sampled at the rising edge. The stream
    // transaction is noted first; a result for it cannot show up in the
    // same cycle anyway.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.take_byte(s_tdata);
            if (m_tvalid === 1'b1 && m_tready)
                sb.check_result(m_tuser, m_tdata[7:0], m_tlast, m_tdata[39:8], m_tdata[52:40]);
        end
    end

    // Append one byte to the outgoing stream.
    task automatic stash_byte(logic [7:0] b);
        stream_q = {stream_q, b};
    endtask

    // Offer one byte, with a random number of idle cycles in front.
    task automatic push_byte(logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_stream();
        while (stream_q.size() != 0)
            push_byte(stream_q.pop_front());
    endtask

    // Stop the sender and let every due result come out. The tail covers
    // bytes that produce nothing but may still sit in the pipe (the output
    // register plus the 4-entry queue).
    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(afd_pkg::cfg_index_t idx, logic [16:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Register writes only happen with the block drained.
    task automatic set_stream(logic [16:0] obj, logic [16:0] rate, logic [16:0] chan,
                              logic [16:0] lim);
        wait_for_results();
        write_reg(afd_pkg::REG_OBJECT_TYPE, obj);
        write_reg(afd_pkg::REG_RATE_INDEX, rate);
        write_reg(afd_pkg::REG_CHANNEL_CONFIG, chan);
        write_reg(afd_pkg::REG_RESYNC_LIMIT, lim);
    endtask

    // Header the block should lock onto under the current settings.
    function automatic adts_hdr_t good_header(int unsigned body, bit crc);
        adts_hdr_t h;
        h.sync0        = 8'hFF;
        h.sync1        = 4'hF;
        h.layer        = 2'b00;
        h.no_crc       = !crc;
        h.profile      = 2'(sb.exp_obj - 3'd1);
        h.rate         = sb.exp_rate;
        h.chan         = sb.exp_chan;
        h.flen         = 13'(body + (crc ? 9 : 7));
        h.extra_blocks = 2'b00;
        return h;
    endfunction

    // Spoil one field so the header check must reject it.
    function automatic adts_hdr_t break_header(adts_hdr_t h);
        case ($urandom_range(8))
            0: h.sync0        = 8'($urandom_range(254));
            1: h.sync1        = 4'($urandom_range(14));
            2: h.layer        = 2'($urandom_range(1, 3));
            3: h.rate         = 4'($urandom_range(13, 15));
            4: h.flen         = 13'($urandom_range(h.no_crc ? 7 : 9));
            5: h.extra_blocks = 2'($urandom_range(1, 3));
            6: h.profile      = h.profile ^ 2'($urandom_range(1, 3));
            7: h.rate         = 4'((h.rate + $urandom_range(1, 12)) % 13);
            default: h.chan   = h.chan ^ 3'($urandom_range(1, 7));
        endcase
        return h;
    endfunction

    // Serialize header, optional CRC word and payload into stream_q.
    task automatic queue_frame(adts_hdr_t h, int unsigned body);
        logic [3:0]  misc;
        logic [10:0] fullness;
        logic        id_bit;
        logic        priv;
        misc     = 4'($urandom);
        fullness = 11'($urandom);
        id_bit   = 1'($urandom);
        priv     = 1'($urandom);
        stash_byte(h.sync0);
        stash_byte({h.sync1, id_bit, h.layer, h.no_crc});
        stash_byte({h.profile, h.rate, priv, h.chan[2]});
        stash_byte({h.chan[1:0], misc, h.flen[12:11]});
        stash_byte(h.flen[10:3]);
        stash_byte({h.flen[2:0], fullness[10:6]});
        stash_byte({fullness[5:0], h.extra_blocks});
        if (!h.no_crc)
            repeat (2) stash_byte(8'($urandom));
        repeat (body) stash_byte(8'($urandom));
    endtask

    // Mostly well-formed frames with random content; the rest are
    // rejected headers and loose noise between frames.
    task automatic run_random(int unsigned n_bytes);
        int unsigned sent;
        int unsigned pick;
        int unsigned body;
        adts_hdr_t   h;
        sent = 0;
        while (sent < n_bytes)
        begin
            pick = $urandom_range(99);
            body = ($urandom_range(29) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
            h    = good_header(body, $urandom_range(1));
            if (pick >= 88)
                repeat ($urandom_range(1, 12)) stash_byte(8'($urandom));
            else
            begin
                if (pick >= 76)
                    h = break_header(h);
                queue_frame(h, body);
            end
            sent += stream_q.size();
            send_stream();
            // occasional hold-off until the output side is empty
            if ($urandom_range(49) == 0)
                wait_for_results();
        end
    endtask

    initial
    begin
        #10_000_000;
        $display("adts_frame_deframer_tb failed");
        $finish;
    end

    initial
    begin
        adts_hdr_t h;
        sb            = new();
        send_idle_pct = 9;
        recv_idle_pct = 67;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        cfg_valid     = 1'b0;
        cfg_index     = afd_pkg::REG_OBJECT_TYPE;
        cfg_data      = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset settings: shortest plain and CRC frames, a frame
        // length not above the header, a multi-block header, then a frame
        // that must lock again after the rejects.
        queue_frame(good_header(1, 0), 1);
        queue_frame(good_header(1, 1), 1);
        h      = good_header(0, 0);
        h.flen = 13'd7;
        queue_frame(h, 0);
        h              = good_header(0, 1);
        h.extra_blocks = 2'd3;
        queue_frame(h, 0);
        queue_frame(good_header(3, 1), 3);
        send_stream();

        // Zero resync budget: back-to-back frames must never slide once.
        set_stream(1, 0, 0, 0);
        repeat (4) queue_frame(good_header($urandom_range(1, 8), $urandom_range(1)), 0);
        stream_q.delete();
        repeat (4)
        begin
            queue_frame(good_header(5, $urandom_range(1)), 5);
            send_stream();
        end

        set_stream(4, 12, 7, 17'h10000);
        run_random(120);

        send_idle_pct = 67;
        recv_idle_pct = 9;
        set_stream($urandom_range(1, 4), $urandom_range(12), $urandom_range(7),
                   $urandom_range(1000, 65535));
        run_random(120);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_stream($urandom_range(1, 4), $urandom_range(12), $urandom_range(7),
                   $urandom_range(1000, 65536));
        run_random(120);

        // Object type 0 and rate 15 can never match (upper data bits set
        // to check masking); after the small budget the stream ends, and
        // everything after that is ignored.
        set_stream(17'h1FFF8, 17'h1FFFF, 17'h1FFFF, 12);
        repeat (3) queue_frame(good_header(5, 0), 5);
        repeat (20) stash_byte(8'($urandom));
        send_stream();

        wait_for_results();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("adts_frame_deframer_tb passed");
        else
            $display("adts_frame_deframer_tb failed");
        $finish;
    end

endmodule

// ===== adts_frame_deframer.f =====
rtl/afd_pkg.sv
rtl/afd_front.sv
rtl/afd_queue.sv
rtl/afd_back.sv
rtl/adts_frame_deframer.sv
sim/adts_frame_deframer_tb.sv
